// File: rtl/delta_list_timer_queue_unit_defines.svh
// Assertion macros used by the timer queue RTL.
`ifndef DELTA_LIST_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLTQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dltq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DLTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dltq assertion failed");

`endif

// File: rtl/dltq_pkg.sv
package dltq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TICK_BITS   = 16;
  localparam int MAX_RESULTS     = 16;

  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_IGNORED  = 2'd1,
    KIND_DROPPED  = 2'd2,
    KIND_EXPIRY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_SUB
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic [7:0]         target;
    logic signed [31:0] payload;
    logic               callback;
  } entry_info_t;

  typedef struct packed {
    cell_op_t    op;
    entry_info_t info;
  } cell_cmd_t;

endpackage

// File: rtl/dltq_if.sv
interface dltq_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        amount;
  logic [7:0]         target;
  logic signed [31:0] payload;
  logic               is_callback;

  modport source (output valid, func, amount, target, payload, is_callback, input ready);
  modport sink   (input valid, func, amount, target, payload, is_callback, output ready);
endinterface

interface dltq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         event_target;
  logic signed [31:0] event_payload;
  logic               event_callback;
  logic               last;

  modport source (output valid, kind, event_target, event_payload, event_callback, last,
                  input ready);
  modport sink   (input valid, kind, event_target, event_payload, event_callback, last,
                  output ready);
endinterface

// File: rtl/dltq_cell.sv
module dltq_cell import dltq_pkg::*; #(
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic [TICK_BITS-1:0] cmd_amount,
  input  logic                 occupied,
  input  logic                 prev_le,
  input  logic [TICK_BITS-1:0] prev_abs,
  input  entry_info_t          prev_info,
  input  logic [TICK_BITS-1:0] next_abs,
  input  entry_info_t          next_info,
  output logic                 le,
  output logic [TICK_BITS-1:0] abs_q,
  output entry_info_t          info_q
);

  // Each cell holds the ticks left until its own deadline, not a delta, so
  // every compare and subtract stays local to the cell.
  logic [TICK_BITS-1:0] abs_r, abs_nxt;
  entry_info_t          info_r, info_nxt;

  assign le     = occupied && (abs_r <= cmd_amount);
  assign abs_q  = abs_r;
  assign info_q = info_r;

  always_comb begin
    abs_nxt  = abs_r;
    info_nxt = info_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (!le) begin
          if (prev_le) begin
            abs_nxt  = cmd_amount;
            info_nxt = cmd.info;
          end else begin
            abs_nxt  = prev_abs;
            info_nxt = prev_info;
          end
        end
      end
      CELL_POP: begin
        abs_nxt  = next_abs;
        info_nxt = next_info;
      end
      CELL_SUB: begin
        abs_nxt = abs_r - cmd_amount;
      end
      default: begin
        abs_nxt  = abs_r;
        info_nxt = info_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    abs_r  <= abs_nxt;
    info_r <= info_nxt;
  end

endmodule

// File: rtl/delta_list_timer_queue_unit.sv
// Channel   Modport  Beat
// in_if     sink     one add or advance item
// out_if    source   one status or expiry result
//
// For an add the cell chain compares and shifts in parallel.
// An advance first latches the elapsed ticks, then pops each expired timer in
// turn and finally takes the remaining ticks off every cell; expiries
// stream one per cycle while the output register is free.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
// A stalled output register holds the expiry loop and blocks new input beats.
`include "delta_list_timer_queue_unit_defines.svh"

module delta_list_timer_queue_unit import dltq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TICK_BITS   = DEF_TICK_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  dltq_in_if.sink        in_if,
  dltq_out_if.source     out_if
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] TICK_MAX32 = (TICK_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << TICK_BITS) - 64'd1);

  state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [TICK_BITS-1:0] elapsed_r, elapsed_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  entry_info_t out_info_r, out_info_nxt;
  logic        out_last_r, out_last_nxt;

  cell_cmd_t            cmd;
  logic [TICK_BITS-1:0] cmd_amount;
  logic [QUEUE_DEPTH-1:0] occ, le_w;
  logic [TICK_BITS-1:0] abs_w [QUEUE_DEPTH];
  entry_info_t          info_w [QUEUE_DEPTH];

  logic [31:0]          amt32, amt_sat32;
  logic [TICK_BITS-1:0] amt_sat;
  logic slot_free, accept, head_due, next_due, load_out;

  assign amt32     = {16'd0, in_if.amount};
  assign amt_sat32 = (amt32 > TICK_MAX32) ? TICK_MAX32 : amt32;
  assign amt_sat   = amt_sat32[TICK_BITS-1:0];

  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && slot_free;
  assign accept      = in_if.valid && in_if.ready;

  assign head_due = occ[0] && (abs_w[0] <= elapsed_r) && (n_r < NW'(MAX_RESULTS));
  assign next_due = occ[1] && (abs_w[1] <= elapsed_r) &&
                    ((n_r + 1'b1) < NW'(MAX_RESULTS));

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                 p_le;
      logic [TICK_BITS-1:0] p_abs, n_abs;
      entry_info_t          p_info, n_info;

      assign occ[gi] = (CW'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign p_le   = 1'b1;
        assign p_abs  = cmd_amount;
        assign p_info = cmd.info;
      end else begin : g_mid
        assign p_le   = le_w[gi-1];
        assign p_abs  = abs_w[gi-1];
        assign p_info = info_w[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign n_abs  = '0;
        assign n_info = '0;
      end else begin : g_inner
        assign n_abs  = abs_w[gi+1];
        assign n_info = info_w[gi+1];
      end

      dltq_cell #(.TICK_BITS(TICK_BITS)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cmd_amount (cmd_amount),
        .occupied   (occ[gi]),
        .prev_le    (p_le),
        .prev_abs   (p_abs),
        .prev_info  (p_info),
        .next_abs   (n_abs),
        .next_info  (n_info),
        .le         (le_w[gi]),
        .abs_q      (abs_w[gi]),
        .info_q     (info_w[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_if.func == FUNC_ADVANCE) state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (!head_due) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.info      = '{target: in_if.target, payload: in_if.payload,
                      callback: in_if.is_callback};
    cmd_amount    = amt_sat;
    count_nxt     = count_r;
    n_nxt         = n_r;
    elapsed_nxt   = elapsed_r;
    load_out      = 1'b0;
    out_kind_nxt  = KIND_ACCEPTED;
    out_info_nxt  = '0;
    out_last_nxt  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_if.func == FUNC_ADD) begin
            load_out = 1'b1;
            if (amt_sat == '0) begin
              out_kind_nxt = KIND_IGNORED;
            end else if (count_r == CW'(QUEUE_DEPTH)) begin
              out_kind_nxt = KIND_DROPPED;
            end else begin
              out_kind_nxt = KIND_ACCEPTED;
              cmd.op       = CELL_INSERT;
              count_nxt    = count_r + 1'b1;
            end
          end else begin
            elapsed_nxt = amt_sat;
            n_nxt       = '0;
          end
        end
      end
      ST_ADV: begin
        if (head_due) begin
          if (slot_free) begin
            load_out     = 1'b1;
            out_kind_nxt = KIND_EXPIRY;
            out_info_nxt = info_w[0];
            out_last_nxt = !next_due;
            cmd.op       = CELL_POP;
            count_nxt    = count_r - 1'b1;
            n_nxt        = n_r + 1'b1;
          end
        end else begin
          // Normally the full elapsed time; when the expiry limit cut the
          // loop short, only enough to bring the new head to zero.
          cmd.op     = CELL_SUB;
          cmd_amount = (occ[0] && abs_w[0] < elapsed_r) ? abs_w[0] : elapsed_r;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    if (load_out) begin
      out_kind_r <= out_kind_nxt;
      out_info_r <= out_info_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.event_target   = out_info_r.target;
  assign out_if.event_payload  = out_info_r.payload;
  assign out_if.event_callback = out_info_r.callback;
  assign out_if.last           = out_last_r;

  `DLTQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH))
  `DLTQ_ASSERT_IMPL(a_expiry_bound, 1'b1, n_r <= NW'(MAX_RESULTS))
  `DLTQ_ASSERT_NEXT(a_pop_count, (state_r == ST_ADV) && load_out,
                    count_r == $past(count_r) - 1'b1)
  `DLTQ_ASSERT_IMPL(a_head_sorted, occ[1], abs_w[0] <= abs_w[1])
  `DLTQ_ASSERT_NEXT(a_sub_ends_advance, cmd.op == CELL_SUB, state_r == ST_IDLE)

endmodule

// File: dv/delta_list_timer_queue_unit_tb.sv
module delta_list_timer_queue_unit_tb import dltq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int TICK_BITS   = DEF_TICK_BITS;

  typedef struct {
    logic               func;
    logic [15:0]        amount;
    logic [7:0]         target;
    logic signed [31:0] payload;
    logic               is_callback;
  } timer_req_t;

  typedef struct {
    kind_t              kind;
    logic [7:0]         target;
    logic signed [31:0] payload;
    logic               callback;
    logic               last;
  } timer_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  dltq_in_if  in_if ();
  dltq_out_if out_if ();

  delta_list_timer_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TICK_BITS  (TICK_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #2 clk = ~clk;

  // Shadow copy of the delta list; entry 0 is the head.
  logic [TICK_BITS-1:0] shadow_delta[QUEUE_DEPTH];
  logic [7:0]           shadow_target[QUEUE_DEPTH];
  logic signed [31:0]   shadow_payload[QUEUE_DEPTH];
  logic                 shadow_callback[QUEUE_DEPTH];
  int unsigned          shadow_count = 0;

  timer_req_t     timer_reqs[$];
  timer_outcome_t queue_outcomes[$];
  timer_req_t     req_in_flight;

  int unsigned reqs_queued   = 0;
  int unsigned reqs_accepted = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count   = 0;

  function automatic timer_outcome_t status_outcome(kind_t kind);
    timer_outcome_t res;
    res.kind     = kind;
    res.target   = '0;
    res.payload  = '0;
    res.callback = 1'b0;
    res.last     = 1'b1;
    return res;
  endfunction

  // Updates the shadow queue for one accepted beat and records the results it causes.
  function automatic void apply_timer_req(timer_req_t req);
    logic [TICK_BITS-1:0] rem;
    int unsigned          pos;
    int unsigned          fired;
    timer_outcome_t       held;
    bit                   have_held;
    rem       = req.amount;
    pos       = 0;
    fired     = 0;
    have_held = 1'b0;
    if (req.func == FUNC_ADD) begin
      if (req.amount == 0) begin
        queue_outcomes.push_back(status_outcome(KIND_IGNORED));
      end else if (shadow_count >= QUEUE_DEPTH) begin
        queue_outcomes.push_back(status_outcome(KIND_DROPPED));
      end else begin
        // Walk past every deadline at or before the new one, so equal deadlines keep order.
        while (pos < shadow_count && shadow_delta[pos] <= rem) begin
          rem -= shadow_delta[pos];
          pos++;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_delta[i]    = shadow_delta[i-1];
          shadow_target[i]   = shadow_target[i-1];
          shadow_payload[i]  = shadow_payload[i-1];
          shadow_callback[i] = shadow_callback[i-1];
        end
        shadow_delta[pos]    = rem;
        shadow_target[pos]   = req.target;
        shadow_payload[pos]  = req.payload;
        shadow_callback[pos] = req.is_callback;
        shadow_count++;
        if (pos + 1 < shadow_count) begin
          shadow_delta[pos+1] -= rem;
        end
        queue_outcomes.push_back(status_outcome(KIND_ACCEPTED));
      end
    end else begin
      while (shadow_count > 0 && shadow_delta[0] <= rem && fired < MAX_RESULTS) begin
        rem -= shadow_delta[0];
        if (have_held) begin
          queue_outcomes.push_back(held);
        end
        held.kind     = KIND_EXPIRY;
        held.target   = shadow_target[0];
        held.payload  = shadow_payload[0];
        held.callback = shadow_callback[0];
        held.last     = 1'b0;
        have_held     = 1'b1;
        fired++;
        for (int i = 1; i < shadow_count; i++) begin
          shadow_delta[i-1]    = shadow_delta[i];
          shadow_target[i-1]   = shadow_target[i];
          shadow_payload[i-1]  = shadow_payload[i];
          shadow_callback[i-1] = shadow_callback[i];
        end
        shadow_count--;
      end
      if (shadow_count > 0) begin
        shadow_delta[0] = (shadow_delta[0] > rem) ? shadow_delta[0] - rem : '0;
      end
      if (have_held) begin
        held.last = 1'b1;
        queue_outcomes.push_back(held);
      end
    end
  endfunction

  function automatic void push_req(logic func, logic [15:0] amount, logic [7:0] target,
                                   logic signed [31:0] payload, logic is_callback);
    timer_req_t req;
    req.func        = func;
    req.amount      = amount;
    req.target      = target;
    req.payload     = payload;
    req.is_callback = is_callback;
    timer_reqs.push_back(req);
    reqs_queued++;
  endfunction

  function automatic void push_random_req();
    logic               func;
    logic [15:0]        amount;
    int unsigned        pick;
    func = ($urandom_range(99) < 55) ? FUNC_ADD : FUNC_ADVANCE;
    pick = $urandom_range(99);
    if (func == FUNC_ADD) begin
      if (pick < 5)       amount = '0;
      else if (pick < 50) amount = 16'($urandom_range(1, 16));
      else if (pick < 80) amount = 16'($urandom_range(1, 400));
      else if (pick < 93) amount = 16'($urandom_range(1, 8000));
      else                amount = 16'($urandom_range(1, 65535));
    end else begin
      if (pick < 10)      amount = '0;
      else if (pick < 60) amount = 16'($urandom_range(1, 24));
      else if (pick < 85) amount = 16'($urandom_range(1, 600));
      else if (pick < 95) amount = 16'($urandom_range(1, 10000));
      else                amount = 16'($urandom_range(10000, 65535));
    end
    push_req(func, amount, 8'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)));
  endfunction

  // Returns once every queued beat is accepted and every result has come back.
  task automatic wait_queue_drained();
    while (reqs_accepted != reqs_queued || queue_outcomes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: a new beat is offered only when the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_timer_req(req_in_flight);
        reqs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (timer_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_in_flight      = timer_reqs.pop_front();
          in_if.valid       <= 1'b1;
          in_if.func        <= req_in_flight.func;
          in_if.amount      <= req_in_flight.amount;
          in_if.target      <= req_in_flight.target;
          in_if.payload     <= req_in_flight.payload;
          in_if.is_callback <= req_in_flight.is_callback;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: each result beat is checked against the oldest outstanding result.
  always @(posedge clk) begin
    timer_outcome_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (queue_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat kind %0d target %0d payload %0d cb %0d last %0d",
                 $time, out_if.kind, out_if.event_target, out_if.event_payload,
                 out_if.event_callback, out_if.last);
        error_count++;
      end else begin
        want = queue_outcomes.pop_front();
        if (out_if.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_if.kind);
          error_count++;
        end
        if (out_if.event_target !== want.target) begin
          $display("%0t: event_target expected %0d actual %0d",
                   $time, want.target, out_if.event_target);
          error_count++;
        end
        if (out_if.event_payload !== want.payload) begin
          $display("%0t: event_payload expected %0d actual %0d",
                   $time, want.payload, out_if.event_payload);
          error_count++;
        end
        if (out_if.event_callback !== want.callback) begin
          $display("%0t: event_callback expected %0d actual %0d",
                   $time, want.callback, out_if.event_callback);
          error_count++;
        end
        if (out_if.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_if.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    idle_plan  = '{0, 65, 0, 13};
    stall_plan = '{0, 0, 65, 13};
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_ADD;
    in_if.amount      = '0;
    in_if.target      = '0;
    in_if.payload     = '0;
    in_if.is_callback = 1'b0;
    out_if.ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // An advance on an empty queue and a zero-duration add.
    push_req(FUNC_ADVANCE, 16'd5, 8'd0, 32'sd0, 1'b0);
    push_req(FUNC_ADD, 16'd0, 8'd255, 32'sh7fffffff, 1'b1);
    // Fill the queue, with several deadlines that collide.
    push_req(FUNC_ADD, 16'd65535, 8'd255, 32'shffffffff, 1'b1);
    push_req(FUNC_ADD, 16'd1, 8'd0, 32'sh80000000, 1'b0);
    push_req(FUNC_ADD, 16'd1, 8'haa, 32'sh55555555, 1'b1);
    push_req(FUNC_ADD, 16'd100, 8'h55, 32'shaaaaaaaa, 1'b0);
    push_req(FUNC_ADD, 16'd50, 8'd3, 32'sd50, 1'b1);
    push_req(FUNC_ADD, 16'd100, 8'd4, 32'sd100, 1'b0);
    push_req(FUNC_ADD, 16'd7, 8'd5, -32'sd7, 1'b1);
    push_req(FUNC_ADD, 16'd3, 8'd6, 32'sd3, 1'b0);
    push_req(FUNC_ADD, 16'd65535, 8'd7, 32'sd0, 1'b0);
    push_req(FUNC_ADD, 16'd20000, 8'd8, 32'sd20000, 1'b1);
    push_req(FUNC_ADD, 16'd2, 8'd9, 32'sd2, 1'b0);
    push_req(FUNC_ADD, 16'd2, 8'd10, -32'sd2, 1'b1);
    push_req(FUNC_ADD, 16'd1, 8'd11, 32'sd1, 1'b0);
    push_req(FUNC_ADD, 16'd500, 8'd12, 32'sd500, 1'b1);
    push_req(FUNC_ADD, 16'd65534, 8'd13, 32'sd65534, 1'b0);
    push_req(FUNC_ADD, 16'd9, 8'd14, 32'sd9, 1'b1);
    // The queue is full now, so this add is dropped.
    push_req(FUNC_ADD, 16'd4, 8'd15, 32'sd4, 1'b0);
    push_req(FUNC_ADVANCE, 16'd0, 8'd0, 32'sd0, 1'b0);
    // Three timers share the first deadline and all expire together.
    push_req(FUNC_ADVANCE, 16'd1, 8'd0, 32'sd0, 1'b0);
    push_req(FUNC_ADVANCE, 16'd65535, 8'hff, 32'shffffffff, 1'b1);
    push_req(FUNC_ADVANCE, 16'd3, 8'd0, 32'sd0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      for (int n = 0; n < 80; n++) begin
        push_random_req();
      end
      // The sender holds off here until the queue has answered everything.
      wait_queue_drained();
    end

    // An advance can still be draining its last expiries; give it time to show extras.
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_if.sv
rtl/dltq_cell.sv
rtl/delta_list_timer_queue_unit.sv
dv/delta_list_timer_queue_unit_tb.sv
